>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the fitness roulette selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/frsu_pkg.sv
// Package with the widths, limits and operation codes of the fitness roulette selector.
package frsu_pkg;

   localparam int DEF_MAX_POPULATION = 256;

   localparam int FIT_W   = 32;
   localparam int TOTAL_W = 40;
   localparam int RUN_W   = TOTAL_W + 1;
   localparam int RAND_W  = 16;
   localparam int POP_W   = 9;
   localparam int IDX_W   = 8;
   localparam int OP_W    = 3;

   localparam logic [FIT_W-1:0]   FIT_MAX   = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [POP_W-1:0]   POP_RESET = 9'd64;

   localparam logic [OP_W-1:0] OP_SET    = 3'd0;
   localparam logic [OP_W-1:0] OP_ADJUST = 3'd1;
   localparam logic [OP_W-1:0] OP_READ   = 3'd2;
   localparam logic [OP_W-1:0] OP_STATS  = 3'd3;
   localparam logic [OP_W-1:0] OP_SELECT = 3'd4;

endpackage

>>> rtl/fitness_roulette_selector_unit.sv
// Top level of the fitness roulette selector: fitness table, statistics and wheel selection.
//
// A request on the req_ channel (valid/stall) carries an opcode: set, adjust, read, stats
// or select. Each request gives exactly one response on the rsp_ channel (valid/stall);
// fields that the opcode does not produce are zero. The csr_ channel writes the population
// size; it is always ready. It must be written only while no request is in flight, which
// the block itself does not enforce. The table lives in one synchronous RAM with a
// registered read port. Requests are handled one at a time, so a read-modify-write never
// overlaps another access to the same entry.
// Steps from acceptance to response valid:
//   set, adjust, read:         modify and write back, response load
//   out-of-range or unused op: response load
//   stats:                     table walk, divider, response load
//   select:                    multiply, slice, table walk to the wheel, response load
// The table walk reads one entry per cycle through the RAM read port.
// The next request can be taken in the cycle after a response is loaded.
// After reset the block clears all MAX_POPULATION RAM entries, one entry per cycle, with
// req_stall high; the population size returns to 64 and the stored total to zero.
// A finished response sits in the output register while rsp_stall is high; the next request
// is accepted meanwhile and its result waits until the output register is free.
module fitness_roulette_selector_unit import frsu_pkg::*; #(
   parameter int MAX_POPULATION = DEF_MAX_POPULATION
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_opcode,
   input  logic [IDX_W-1:0]         req_entry_index,
   input  logic signed [FIT_W-1:0]  req_fitness_value,
   input  logic [RAND_W-1:0]        req_random_fraction,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [FIT_W-1:0]         rsp_fitness_read,
   output logic [IDX_W-1:0]         rsp_selected_index,
   output logic [TOTAL_W-1:0]       rsp_fitness_total,
   output logic [FIT_W-1:0]         rsp_fitness_best,
   output logic [FIT_W-1:0]         rsp_fitness_worst,
   output logic [FIT_W-1:0]         rsp_fitness_average,
   output logic [IDX_W-1:0]         rsp_best_entry,
   output logic                     rsp_index_error,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [POP_W-1:0]         csr_population_size
);

   `include "assert_macros.svh"

   localparam int AW      = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
   localparam int POP_CAP = (MAX_POPULATION < 511) ? MAX_POPULATION : 511;
   localparam int HALF_W  = TOTAL_W / 2;
   localparam int PROD_W  = RAND_W + HALF_W;
   localparam int FULL_W  = RAND_W + TOTAL_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POPULATION - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_RMW, ST_MUL, ST_SLICE, ST_WALK, ST_DIV, ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [POP_W-1:0]   population_ff, population_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [FIT_W-1:0]   val_ff, val_in;
   logic [RAND_W-1:0]  rnd_ff, rnd_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [POP_W-1:0]   cnt_ff, cnt_in;
   logic [POP_W-1:0]   proc_ff, proc_in;
   logic               dv_ff, dv_in;
   logic [RUN_W-1:0]   acc_ff, acc_in;
   logic [FIT_W-1:0]   best_ff, best_in;
   logic [FIT_W-1:0]   worst_ff, worst_in;
   logic [POP_W-1:0]   best_i_ff, best_i_in;
   logic [PROD_W-1:0]  plo_ff, plo_in;
   logic [PROD_W-1:0]  phi_ff, phi_in;
   logic [TOTAL_W-1:0] slice_ff, slice_in;
   logic [TOTAL_W-1:0] stored_total_ff, stored_total_in;
   logic               div_start_ff, div_start_in;

   logic [FIT_W-1:0]   res_read_ff, res_read_in;
   logic [IDX_W-1:0]   res_sel_ff, res_sel_in;
   logic [TOTAL_W-1:0] res_total_ff, res_total_in;
   logic [FIT_W-1:0]   res_best_ff, res_best_in;
   logic [FIT_W-1:0]   res_worst_ff, res_worst_in;
   logic [FIT_W-1:0]   res_avg_ff, res_avg_in;
   logic [IDX_W-1:0]   res_bi_ff, res_bi_in;
   logic               res_err_ff, res_err_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIT_W-1:0]   rsp_read_ff, rsp_read_in;
   logic [IDX_W-1:0]   rsp_sel_ff, rsp_sel_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic [FIT_W-1:0]   rsp_best_ff, rsp_best_in;
   logic [FIT_W-1:0]   rsp_worst_ff, rsp_worst_in;
   logic [FIT_W-1:0]   rsp_avg_ff, rsp_avg_in;
   logic [IDX_W-1:0]   rsp_bi_ff, rsp_bi_in;
   logic               rsp_err_ff, rsp_err_in;

   logic [FIT_W-1:0]   mem [MAX_POPULATION];
   logic [FIT_W-1:0]   rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [FIT_W-1:0]   wr_data;

   logic [POP_W-1:0]   pop;
   logic               req_take;
   logic               req_err;
   logic               val_neg;
   logic [FIT_W-1:0]   val_mag;
   logic [FIT_W:0]     adj_sum;
   logic [FIT_W-1:0]   new_fit;
   logic [RUN_W-1:0]   run_sum;
   logic [RUN_W-1:0]   stat_total;
   logic               best_upd;
   logic [FIT_W-1:0]   best_new;
   logic [POP_W-1:0]   best_i_new;
   logic [FIT_W-1:0]   worst_new;
   logic               walk_last;
   logic [FULL_W-1:0]  full_prod;
   logic               out_free;
   logic               out_load;
   logic               div_done;
   logic [TOTAL_W-1:0] div_quot;

   // A register value of zero acts as one; values above the table depth act as the depth.
   always_comb begin
      if (population_ff == '0) begin
         pop = POP_W'(1);
      end else if (population_ff > POP_W'(POP_CAP)) begin
         pop = POP_W'(POP_CAP);
      end else begin
         pop = population_ff;
      end
   end

   assign req_take = req_valid && !req_stall;
   assign req_err  = {1'b0, req_entry_index} >= pop;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Read-modify-write arithmetic on the entry fetched in the accepting cycle.
   assign val_neg = val_ff[FIT_W-1];
   assign val_mag = val_neg ? FIT_W'(~val_ff + 1'b1) : val_ff;
   assign adj_sum = {1'b0, rd_data_ff} + {1'b0, val_mag};

   always_comb begin
      case (op_ff)
         OP_SET: begin
            new_fit = val_neg ? '0 : val_ff;
         end
         OP_ADJUST: begin
            if (val_neg) begin
               new_fit = (val_mag >= rd_data_ff) ? '0 : rd_data_ff - val_mag;
            end else begin
               new_fit = adj_sum[FIT_W] ? FIT_MAX : adj_sum[FIT_W-1:0];
            end
         end
         default: begin
            new_fit = rd_data_ff;
         end
      endcase
   end

   // Walk datapath: one table entry per cycle.
   assign run_sum    = acc_ff + {{(RUN_W-FIT_W){1'b0}}, rd_data_ff};
   assign stat_total = run_sum[TOTAL_W] ? {1'b0, TOTAL_MAX} : run_sum;
   assign best_upd   = rd_data_ff > best_ff;
   assign best_new   = best_upd ? rd_data_ff : best_ff;
   assign best_i_new = best_upd ? proc_ff : best_i_ff;
   assign worst_new  = (rd_data_ff < worst_ff) ? rd_data_ff : worst_ff;
   assign walk_last  = proc_ff == (pop - 1'b1);
   assign full_prod  = {phi_ff, {HALF_W{1'b0}}} + {{(FULL_W-PROD_W){1'b0}}, plo_ff};

   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            rd_addr = AW'(req_entry_index);
         end
         ST_RMW: begin
            wr_en   = (op_ff == OP_SET) || (op_ff == OP_ADJUST);
            wr_addr = AW'(idx_ff);
            wr_data = new_fit;
         end
         ST_WALK: begin
            rd_addr = AW'(cnt_ff);
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      population_in   = population_ff;
      op_in           = op_ff;
      idx_in          = idx_ff;
      val_in          = val_ff;
      rnd_in          = rnd_ff;
      clr_in          = clr_ff;
      cnt_in          = cnt_ff;
      proc_in         = proc_ff;
      dv_in           = 1'b0;
      acc_in          = acc_ff;
      best_in         = best_ff;
      worst_in        = worst_ff;
      best_i_in       = best_i_ff;
      plo_in          = plo_ff;
      phi_in          = phi_ff;
      slice_in        = slice_ff;
      stored_total_in = stored_total_ff;
      div_start_in    = 1'b0;
      res_read_in     = res_read_ff;
      res_sel_in      = res_sel_ff;
      res_total_in    = res_total_ff;
      res_best_in     = res_best_ff;
      res_worst_in    = res_worst_ff;
      res_avg_in      = res_avg_ff;
      res_bi_in       = res_bi_ff;
      res_err_in      = res_err_ff;
      out_load        = 1'b0;

      if (csr_valid && csr_ready) begin
         population_in = csr_population_size;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               op_in        = req_opcode;
               idx_in       = req_entry_index;
               val_in       = req_fitness_value;
               rnd_in       = req_random_fraction;
               res_read_in  = '0;
               res_sel_in   = '0;
               res_total_in = '0;
               res_best_in  = '0;
               res_worst_in = '0;
               res_avg_in   = '0;
               res_bi_in    = '0;
               res_err_in   = 1'b0;
               cnt_in       = '0;
               acc_in       = '0;
               best_in      = '0;
               worst_in     = FIT_MAX;
               best_i_in    = '0;
               case (req_opcode)
                  OP_SET, OP_ADJUST, OP_READ: begin
                     res_err_in = req_err;
                     state_in   = req_err ? ST_FINISH : ST_RMW;
                  end
                  OP_STATS: begin
                     state_in = ST_WALK;
                  end
                  OP_SELECT: begin
                     state_in = ST_MUL;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_RMW: begin
            res_read_in = new_fit;
            state_in    = ST_FINISH;
         end
         ST_MUL: begin
            // The 16 by 40 product is built from two 16 by 20 halves.
            plo_in   = rnd_ff * stored_total_ff[HALF_W-1:0];
            phi_in   = rnd_ff * stored_total_ff[TOTAL_W-1:HALF_W];
            state_in = ST_SLICE;
         end
         ST_SLICE: begin
            slice_in = full_prod[FULL_W-1:RAND_W];
            state_in = ST_WALK;
         end
         ST_WALK: begin
            // Issue one read per cycle; the data is processed in the next cycle.
            if (cnt_ff < pop) begin
               cnt_in = cnt_ff + 1'b1;
               dv_in  = 1'b1;
            end
            proc_in = cnt_ff;
            if (dv_ff) begin
               if (op_ff == OP_STATS) begin
                  acc_in    = stat_total;
                  best_in   = best_new;
                  worst_in  = worst_new;
                  best_i_in = best_i_new;
                  if (walk_last) begin
                     dv_in           = 1'b0;
                     stored_total_in = stat_total[TOTAL_W-1:0];
                     res_total_in    = stat_total[TOTAL_W-1:0];
                     res_best_in     = best_new;
                     res_worst_in    = worst_new;
                     res_bi_in       = IDX_W'(best_i_new);
                     div_start_in    = 1'b1;
                     state_in        = ST_DIV;
                  end
               end else begin
                  acc_in = run_sum;
                  if (run_sum >= {1'b0, slice_ff}) begin
                     dv_in      = 1'b0;
                     res_sel_in = IDX_W'(proc_ff);
                     state_in   = ST_FINISH;
                  end else if (walk_last) begin
                     // The wheel was never reached: the last entry in use wins.
                     dv_in      = 1'b0;
                     res_sel_in = IDX_W'(pop - 1'b1);
                     state_in   = ST_FINISH;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_avg_in = div_quot[FIT_W-1:0];
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_read_in  = rsp_read_ff;
      rsp_sel_in   = rsp_sel_ff;
      rsp_total_in = rsp_total_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_worst_in = rsp_worst_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_bi_in    = rsp_bi_ff;
      rsp_err_in   = rsp_err_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_read_in  = res_read_ff;
         rsp_sel_in   = res_sel_ff;
         rsp_total_in = res_total_ff;
         rsp_best_in  = res_best_ff;
         rsp_worst_in = res_worst_ff;
         rsp_avg_in   = res_avg_ff;
         rsp_bi_in    = res_bi_ff;
         rsp_err_in   = res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      rnd_ff       <= rnd_in;
      cnt_ff       <= cnt_in;
      proc_ff      <= proc_in;
      acc_ff       <= acc_in;
      best_ff      <= best_in;
      worst_ff     <= worst_in;
      best_i_ff    <= best_i_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      slice_ff     <= slice_in;
      res_read_ff  <= res_read_in;
      res_sel_ff   <= res_sel_in;
      res_total_ff <= res_total_in;
      res_best_ff  <= res_best_in;
      res_worst_ff <= res_worst_in;
      res_avg_ff   <= res_avg_in;
      res_bi_ff    <= res_bi_in;
      res_err_ff   <= res_err_in;
      rsp_read_ff  <= rsp_read_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_total_ff <= rsp_total_in;
      rsp_best_ff  <= rsp_best_in;
      rsp_worst_ff <= rsp_worst_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_bi_ff    <= rsp_bi_in;
      rsp_err_ff   <= rsp_err_in;
      if (reset) begin
         state_ff        <= ST_CLEAR;
         population_ff   <= POP_RESET;
         clr_ff          <= '0;
         dv_ff           <= 1'b0;
         stored_total_ff <= '0;
         div_start_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         population_ff   <= population_in;
         clr_ff          <= clr_in;
         dv_ff           <= dv_in;
         stored_total_ff <= stored_total_in;
         div_start_ff    <= div_start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   frsu_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (stored_total_ff),
      .divisor  (pop),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_stall           = state_ff != ST_IDLE;
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fitness_read    = rsp_read_ff;
   assign rsp_selected_index  = rsp_sel_ff;
   assign rsp_fitness_total   = rsp_total_ff;
   assign rsp_fitness_best    = rsp_best_ff;
   assign rsp_fitness_worst   = rsp_worst_ff;
   assign rsp_fitness_average = rsp_avg_ff;
   assign rsp_best_entry      = rsp_bi_ff;
   assign rsp_index_error     = rsp_err_ff;

   `ASSERT_IMP(a_write_states, clock, reset, wr_en,
      (state_ff == ST_CLEAR) || (state_ff == ST_RMW))
   `ASSERT_IMP(a_walk_in_range, clock, reset, dv_ff, proc_ff < pop)
   `ASSERT_IMP(a_div_done_state, clock, reset, div_done, state_ff == ST_DIV)
   `ASSERT_IMP(a_no_overwrite, clock, reset, out_load, !(rsp_valid_ff && rsp_stall))
   `ASSERT_NXT(a_stats_stores_total, clock, reset,
      (state_ff == ST_WALK) && (state_in == ST_DIV), stored_total_ff == res_total_ff)

endmodule

>>> rtl/frsu_divider.sv
// Restoring divider, one quotient bit per cycle, for the population average.
module frsu_divider import frsu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TOTAL_W-1:0] dividend,
   input  logic [POP_W-1:0]   divisor,
   output logic               done,
   output logic [TOTAL_W-1:0] quotient
);

   localparam int CNT_W = $clog2(TOTAL_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TOTAL_W - 1);

   logic [TOTAL_W-1:0] work_ff, work_in;
   logic [POP_W-1:0]   rem_ff, rem_in;
   logic [POP_W-1:0]   dsr_ff, dsr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [POP_W:0]     trial;
   logic               ge;

   assign trial = {rem_ff, work_ff[TOTAL_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         work_in  = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // When the trial falls short it is below the divisor and fits the remainder.
         rem_in   = ge ? POP_W'(trial - {1'b0, dsr_ff}) : trial[POP_W-1:0];
         work_in  = {work_ff[TOTAL_W-2:0], ge};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule
